@@ sv/i2c_bm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c_bm_pkg
// Shared types and constants for the byte level I2C master.
// ----------------------------------------------------------------------------
package i2c_bm_pkg;

    localparam int unsigned PHASE_W = 16;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd1;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

endpackage

@@ sv/i2c_byte_master.sv @@
// ----------------------------------------------------------------------------
// i2c_byte_master
// Each result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle while the output is not stalled; each item is one bus timing tick.
// Every tick is resolved by one pass of next-state logic into the state
// and result registers; the output register is freed in the same cycle it
// is taken. Reset (synchronous, active low) idles the block, releases both
// lines and loads phase_ticks with 1.
// ----------------------------------------------------------------------------
module i2c_byte_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [i2c_bm_pkg::PHASE_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_mode,
    input  logic [i2c_bm_pkg::BYTE_W-1:0]   i_tx_byte,
    input  logic                            i_nack_out,
    input  logic                            i_scl_in,
    input  logic                            i_sda_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_scl_drive_low,
    output logic                            o_sda_drive_low,
    output logic                            o_ready_res,
    output logic                            o_done_res,
    output logic [i2c_bm_pkg::BYTE_W-1:0]   o_rx_byte,
    output logic                            o_ack_bit
);
    import i2c_bm_pkg::*;

    logic [PHASE_W-1:0] r_phase_ticks;
    t_cmd               r_cmd,     n_cmd;
    logic [2:0]         r_step,    n_step;
    logic [3:0]         r_bit,     n_bit;
    logic [PHASE_W-1:0] r_wc,      n_wc;
    logic [BYTE_W-1:0]  r_shift,   n_shift;
    logic [BYTE_W-1:0]  r_rx,      n_rx;
    logic               r_ack,     n_ack;
    logic               r_nack,    n_nack;
    logic               r_restart, n_restart;
    logic               r_scl_low, n_scl_low;
    logic               r_sda_low, n_sda_low;
    logic               r_ready,   n_ready;
    logic               r_done,    n_done;
    logic               r_out_valid;

    logic               c_stop;
    logic               c_hold;
    logic               c_writing;
    logic               c_bit_val;
    logic               c_advance;
    logic               c_finish;
    logic [PHASE_W-1:0] c_lim;
    logic [PHASE_W-1:0] c_wc_inc;
    logic               in_acc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign c_lim = (r_phase_ticks == '0) ? PHASE_W'(1) : r_phase_ticks;

    always_comb begin
        n_cmd     = r_cmd;
        n_step    = r_step;
        n_bit     = r_bit;
        n_wc      = r_wc;
        n_shift   = r_shift;
        n_rx      = r_rx;
        n_ack     = r_ack;
        n_nack    = r_nack;
        n_restart = r_restart;
        n_scl_low = r_scl_low;
        n_sda_low = r_sda_low;
        n_done    = 1'b0;
        n_ready   = (r_cmd == CMD_IDLE);
        c_stop    = 1'b0;
        c_hold    = 1'b0;
        c_writing = 1'b0;
        c_bit_val = 1'b0;
        c_advance = 1'b0;
        c_finish  = 1'b0;
        c_wc_inc  = '0;

        // command launch
        if (n_ready && (i_mode inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ})) begin
            n_cmd  = t_cmd'(i_mode);
            n_wc   = '0;
            n_bit  = '0;
            n_step = (t_cmd'(i_mode) == CMD_START && !r_restart) ? 3'd5 : 3'd0;
            if (t_cmd'(i_mode) == CMD_WRITE) begin
                n_shift = i_tx_byte;
            end
            if (t_cmd'(i_mode) == CMD_READ) begin
                n_shift = '0;
                n_nack  = i_nack_out;
            end
        end

        // zero-time steps and SCL waits, up to the next delay or the end
        for (int k = 0; k < 6; k++) begin
            if (!c_stop && n_cmd != CMD_IDLE) begin
                c_advance = 1'b0;
                c_finish  = 1'b0;
                c_writing = (n_cmd == CMD_WRITE) ? (n_bit < 4'd8) : (n_bit == 4'd8);
                c_bit_val = (n_bit < 4'd8) ? n_shift[BYTE_W-1] : n_nack;
                case (n_cmd)
                    CMD_START: begin
                        case (n_step)
                            3'd0: begin n_sda_low = 1'b0; n_step = 3'd1; end
                            3'd1, 3'd4, 3'd6: begin c_hold = 1'b1; c_stop = 1'b1; end
                            3'd2: begin n_scl_low = 1'b0; n_step = 3'd3; end
                            3'd3: begin
                                if (i_scl_in) n_step = 3'd4;
                                else c_stop = 1'b1;
                            end
                            3'd5: begin n_sda_low = 1'b1; n_step = 3'd6; end
                            default: begin
                                n_scl_low = 1'b1;
                                n_restart = 1'b1;
                                c_finish  = 1'b1;
                            end
                        endcase
                    end
                    CMD_STOP: begin
                        case (n_step)
                            3'd0: begin n_sda_low = 1'b1; n_step = 3'd1; end
                            3'd1, 3'd5: begin c_hold = 1'b1; c_stop = 1'b1; end
                            3'd2: begin n_scl_low = 1'b0; n_step = 3'd3; end
                            3'd3: begin
                                if (i_scl_in) n_step = 3'd4;
                                else c_stop = 1'b1;
                            end
                            3'd4: begin n_sda_low = 1'b0; n_step = 3'd5; end
                            default: begin
                                n_restart = 1'b0;
                                c_finish  = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        if (c_writing) begin
                            case (n_step)
                                3'd0: begin n_sda_low = !c_bit_val; n_step = 3'd1; end
                                3'd1, 3'd3: begin c_hold = 1'b1; c_stop = 1'b1; end
                                3'd2: begin n_scl_low = 1'b0; n_step = 3'd3; end
                                3'd4: begin
                                    if (i_scl_in) n_step = 3'd5;
                                    else c_stop = 1'b1;
                                end
                                default: begin
                                    n_scl_low = 1'b1;
                                    if (n_bit < 4'd8) n_shift = {n_shift[BYTE_W-2:0], 1'b0};
                                    c_advance = 1'b1;
                                end
                            endcase
                        end else begin
                            case (n_step)
                                3'd0: begin n_sda_low = 1'b0; n_step = 3'd1; end
                                3'd1, 3'd4: begin c_hold = 1'b1; c_stop = 1'b1; end
                                3'd2: begin n_scl_low = 1'b0; n_step = 3'd3; end
                                3'd3: begin
                                    if (i_scl_in) n_step = 3'd4;
                                    else c_stop = 1'b1;
                                end
                                default: begin
                                    if (n_bit < 4'd8) n_shift = {n_shift[BYTE_W-2:0], i_sda_in};
                                    else n_ack = i_sda_in;
                                    n_scl_low = 1'b1;
                                    c_advance = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
                if (c_advance) begin
                    n_step = 3'd0;
                    n_bit  = n_bit + 4'd1;
                    if (n_bit >= 4'd9) c_finish = 1'b1;
                end
                if (c_finish) begin
                    if (n_cmd == CMD_READ) n_rx = n_shift;
                    n_cmd  = CMD_IDLE;
                    n_step = 3'd0;
                    n_wc   = '0;
                    n_bit  = '0;
                    n_done = 1'b1;
                    c_stop = 1'b1;
                end
            end
        end

        // one delay tick
        if (c_hold) begin
            c_wc_inc = n_wc + PHASE_W'(1);
            if (c_wc_inc >= c_lim || c_wc_inc == '0) begin
                n_wc   = '0;
                n_step = n_step + 3'd1;
            end else begin
                n_wc = c_wc_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_cmd         <= CMD_IDLE;
            r_step        <= '0;
            r_bit         <= '0;
            r_wc          <= '0;
            r_shift       <= '0;
            r_rx          <= '0;
            r_ack         <= 1'b0;
            r_nack        <= 1'b0;
            r_restart     <= 1'b0;
            r_scl_low     <= 1'b0;
            r_sda_low     <= 1'b0;
            r_ready       <= 1'b0;
            r_done        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_phase_ticks <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_cmd       <= n_cmd;
                r_step      <= n_step;
                r_bit       <= n_bit;
                r_wc        <= n_wc;
                r_shift     <= n_shift;
                r_rx        <= n_rx;
                r_ack       <= n_ack;
                r_nack      <= n_nack;
                r_restart   <= n_restart;
                r_scl_low   <= n_scl_low;
                r_sda_low   <= n_sda_low;
                r_ready     <= n_ready;
                r_done      <= n_done;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result item is the state left by the last accepted tick
    assign o_out_valid     = r_out_valid;
    assign o_scl_drive_low = r_scl_low;
    assign o_sda_drive_low = r_sda_low;
    assign o_ready_res     = r_ready;
    assign o_done_res      = r_done;
    assign o_rx_byte       = r_rx;
    assign o_ack_bit       = r_ack;

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_IDLE) |-> (r_step == 3'd0 && r_bit == 4'd0 && r_wc == '0))
        else $error("idle with stale sequencing state");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8)
        else $error("bit index out of range");

    a_no_instant_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_ready_res))
        else $error("command finished on its launch tick");

    a_restart_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_restart) |-> (o_done_res && o_scl_drive_low))
        else $error("restart flag set outside a finished start");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule
